[sv/cfb_pkg.sv]
package cfb_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] COLOUR_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] LEN_STATUS   = 8'h00;
    localparam logic [BYTE_W-1:0] LEN_COLOUR   = 8'h01;

    // 0x31 with its bit order reversed
    localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_INIT      = 8'h00;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STATUS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOUR = 2'd2;

    localparam logic CMD_STATUS = 1'b0;
    localparam logic CMD_COLOUR = 1'b1;

    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] POS_HEADER = 3'd0;
    localparam logic [POS_W-1:0] POS_CODE   = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN    = 3'd2;
    localparam logic [POS_W-1:0] POS_DATA   = 3'd3;
    localparam logic [POS_W-1:0] POS_TAIL   = 3'd4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] colour;
    } frame_desc_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/cfb_front.sv]
module cfb_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cfb_pkg::BYTE_W-1:0]         s_tdata,
    input  logic                               s_tuser,
    input  logic                               cfg_we,
    input  logic [cfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cfb_pkg::BYTE_W-1:0]         cfg_wdata,
    input  cfb_pkg::queue_status_t             q_status,
    output logic                               push,
    output cfb_pkg::frame_desc_t               push_desc
);

    logic [cfb_pkg::BYTE_W-1:0] header_reg;
    logic [cfb_pkg::BYTE_W-1:0] status_code_reg;
    logic [cfb_pkg::BYTE_W-1:0] colour_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg      <= cfb_pkg::HEADER_RESET;
            status_code_reg <= cfb_pkg::STATUS_RESET;
            colour_code_reg <= cfb_pkg::COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                cfb_pkg::REG_HEADER: header_reg      <= cfg_wdata;
                cfb_pkg::REG_STATUS: status_code_reg <= cfg_wdata;
                cfb_pkg::REG_COLOUR: colour_code_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_desc.kind   = s_tuser;
        push_desc.header = header_reg;
        push_desc.code   = (s_tuser == cfb_pkg::CMD_COLOUR) ? colour_code_reg
                                                            : status_code_reg;
        push_desc.colour = s_tdata;
    end

endmodule

[sv/cfb_queue.sv]
module cfb_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cfb_pkg::frame_desc_t   push_desc,
    input  logic                   pop,
    output cfb_pkg::frame_desc_t   head_desc,
    output cfb_pkg::queue_status_t status
);

    cfb_pkg::frame_desc_t              q_reg [cfb_pkg::QDEPTH];
    logic [cfb_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [cfb_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [cfb_pkg::QCNT_W-1:0]        count_reg;
    logic [cfb_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [cfb_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [cfb_pkg::QCNT_W-1:0]        count_next;

    localparam logic [cfb_pkg::QPTR_W-1:0] PTR_LAST = cfb_pkg::QPTR_W'(cfb_pkg::QDEPTH - 1);
    localparam logic [cfb_pkg::QCNT_W-1:0] CNT_FULL = cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH);

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign head_desc    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.valid)
        else $error("queue pop while empty");

endmodule

[sv/cfb_back.sv]
module cfb_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfb_pkg::frame_desc_t       head_desc,
    input  cfb_pkg::queue_status_t     q_status,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cfb_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [cfb_pkg::POS_W-1:0]   pos_reg;
    logic [cfb_pkg::POS_W-1:0]   pos_next;
    cfb_pkg::frame_desc_t        desc_reg;
    cfb_pkg::frame_desc_t        desc_next;
    logic [cfb_pkg::BYTE_W-1:0]  crc_reg;
    logic [cfb_pkg::BYTE_W-1:0]  crc_next;
    logic                        m_tvalid_reg;
    logic                        m_tvalid_next;
    logic [cfb_pkg::BYTE_W-1:0]  m_tdata_reg;
    logic [cfb_pkg::BYTE_W-1:0]  m_tdata_next;
    logic                        m_tlast_reg;
    logic                        m_tlast_next;

    cfb_pkg::frame_desc_t        src_desc;
    logic [cfb_pkg::POS_W-1:0]   src_pos;
    logic [cfb_pkg::BYTE_W-1:0]  src_crc;
    logic [cfb_pkg::BYTE_W-1:0]  cur_byte;
    logic                        cur_last;
    logic                        advance;
    logic                        emit;

    assign advance = !m_tvalid_reg || m_tready;
    assign emit    = advance && (busy_reg || q_status.valid);
    assign pop     = advance && !busy_reg && q_status.valid;

    assign src_desc = busy_reg ? desc_reg : head_desc;
    assign src_pos  = busy_reg ? pos_reg  : cfb_pkg::POS_HEADER;
    assign src_crc  = busy_reg ? crc_reg  : cfb_pkg::CRC_INIT;

    always_comb
    begin
        cur_last = 1'b0;
        case (src_pos)
            cfb_pkg::POS_HEADER: cur_byte = src_desc.header;
            cfb_pkg::POS_CODE:   cur_byte = src_desc.code;
            cfb_pkg::POS_LEN:
            begin
                cur_byte = (src_desc.kind == cfb_pkg::CMD_COLOUR) ? cfb_pkg::LEN_COLOUR
                                                                  : cfb_pkg::LEN_STATUS;
            end
            cfb_pkg::POS_DATA:
            begin
                if (src_desc.kind == cfb_pkg::CMD_COLOUR)
                begin
                    cur_byte = src_desc.colour;
                end
                else
                begin
                    cur_byte = src_crc;
                    cur_last = 1'b1;
                end
            end
            default:
            begin
                cur_byte = src_crc;
                cur_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        desc_next     = desc_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (advance)
        begin
            m_tvalid_next = emit;
            if (emit)
            begin
                m_tdata_next = cur_byte;
                m_tlast_next = cur_last;
                busy_next    = !cur_last;
                pos_next     = src_pos + 1'b1;
                desc_next    = src_desc;
                crc_next     = cfb_pkg::crc8_update(src_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        desc_reg    <= desc_next;
        crc_reg     <= crc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_busy_pos: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg != cfb_pkg::POS_HEADER && pos_reg <= cfb_pkg::POS_TAIL))
        else $error("serializer position out of range");

    a_pop_emits_header: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid_reg && !m_tlast_reg && busy_reg))
        else $error("frame start not emitted after pop");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cur_last) |=> !busy_reg)
        else $error("serializer busy after last beat");

endmodule

[sv/command_frame_builder_crc8_core.sv]
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | s_tdata[7:0] team_colour, s_tuser[0] command
// m       | out | m_tvalid/m_tready | m_tdata[7:0] frame_byte, m_tlast last_byte
// cfg     | in  | cfg_we            | cfg_addr register index, cfg_wdata value
//
// One beat leaves per cycle unless m_tready stalls the output; a status frame has 4 beats,
// a colour frame 5; the byte serializer registers the header as it pops a request.
// Requests wait in a 2-entry queue; s_tready drops only while that queue is full.
// The CRC is folded in one byte per cycle with each emitted beat unless m_tready stalls.
// Reset (rst_n low, asynchronous) empties the queue, drops m_tvalid, loads register defaults.
// A stall on m_tready holds the output beat; if requests keep arriving, the queue fills and drops s_tready.
module command_frame_builder_crc8_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] team_colour
    input  logic [0:0]                         s_tuser,  // [0] command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,  // [7:0] frame_byte
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [cfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [7:0]                         cfg_wdata
);

    cfb_pkg::queue_status_t q_status;
    cfb_pkg::frame_desc_t   push_desc;
    cfb_pkg::frame_desc_t   head_desc;
    logic                   push;
    logic                   pop;

    cfb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    cfb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    cfb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam logic [cfb_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic                       kind;
        logic [cfb_pkg::BYTE_W-1:0] colour;
    } cmd_req_t;

    typedef struct packed {
        logic [cfb_pkg::BYTE_W-1:0] data;
        logic                       last;
    } frame_beat_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [cfb_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [7:0]                     cfg_wdata = '0;

    cmd_req_t    cmd_requests[$];
    frame_beat_t frame_beats_due[$];

    logic [cfb_pkg::BYTE_W-1:0] header_reg = cfb_pkg::HEADER_RESET;
    logic [cfb_pkg::BYTE_W-1:0] status_reg = cfb_pkg::STATUS_RESET;
    logic [cfb_pkg::BYTE_W-1:0] colour_reg = cfb_pkg::COLOUR_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int beats_checked = 0;
    int status_frames = 0;
    int colour_frames = 0;
    int cycle_count   = 0;

    command_frame_builder_crc8_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // bit-serial form of the reflected CRC-8
    function automatic logic [cfb_pkg::BYTE_W-1:0] crc8_fold(
        input logic [cfb_pkg::BYTE_W-1:0] crc,
        input logic [cfb_pkg::BYTE_W-1:0] b
    );
        logic mix;
        for (int i = 0; i < cfb_pkg::BYTE_W; i++)
        begin
            mix = crc[0] ^ b[i];
            crc = crc >> 1;
            if (mix)
                crc = crc ^ cfb_pkg::CRC_POLY_REFL;
        end
        return crc;
    endfunction

    function automatic void build_frame_beats(input cmd_req_t req);
        logic [cfb_pkg::BYTE_W-1:0] body[$];
        logic [cfb_pkg::BYTE_W-1:0] crc;
        body.push_back(header_reg);
        if (req.kind == cfb_pkg::CMD_COLOUR)
        begin
            body.push_back(colour_reg);
            body.push_back(cfb_pkg::LEN_COLOUR);
            body.push_back(req.colour);
            colour_frames++;
        end
        else
        begin
            body.push_back(status_reg);
            body.push_back(cfb_pkg::LEN_STATUS);
            status_frames++;
        end
        crc = cfb_pkg::CRC_INIT;
        foreach (body[i])
        begin
            crc = crc8_fold(crc, body[i]);
            frame_beats_due.push_back(frame_beat_t'{data: body[i], last: 1'b0});
        end
        frame_beats_due.push_back(frame_beat_t'{data: crc, last: 1'b1});
    endfunction

    function automatic logic [cfb_pkg::BYTE_W-1:0] edge_or_random_byte();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic cfg_write(input logic [cfb_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            cfb_pkg::REG_HEADER: header_reg = value;
            cfb_pkg::REG_STATUS: status_reg = value;
            cfb_pkg::REG_COLOUR: colour_reg = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_req(input logic kind, input logic [cfb_pkg::BYTE_W-1:0] colour);
        cmd_requests.push_back(cmd_req_t'{kind: kind, colour: colour});
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 36;
                recv_idle_pct = 45;
            end
            1:
            begin
                send_idle_pct = 45;
                recv_idle_pct = 36;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // hold until every frame has left the block
    task automatic drain();
        while (cmd_requests.size() != 0 || s_tvalid || frame_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        cmd_req_t nxt;
        logic     drive;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                build_frame_beats(cmd_req_t'{kind: s_tuser[0], colour: s_tdata});
            if (!s_tvalid || s_tready)
            begin
                drive = (cmd_requests.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                if (drive)
                begin
                    nxt = cmd_requests.pop_front();
                    s_tdata    <= nxt.colour;
                    s_tuser[0] <= nxt.kind;
                end
                s_tvalid <= drive;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : frame_monitor
        frame_beat_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (frame_beats_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected beat: data %02h last %0b", m_tdata, m_tlast);
                end
                else
                begin
                    want = frame_beats_due.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"Beat mismatch: expected data %02h last %0b,",
                                      " got data %02h last %0b"},
                                     want.data, want.last, m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, frame_beats_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(0);

        // register defaults, colour byte extremes, status query ignoring its colour
        push_req(cfb_pkg::CMD_STATUS, 8'h00);
        push_req(cfb_pkg::CMD_STATUS, 8'hFF);
        push_req(cfb_pkg::CMD_COLOUR, 8'h00);
        push_req(cfb_pkg::CMD_COLOUR, 8'hFF);
        push_req(cfb_pkg::CMD_COLOUR, 8'h5A);
        push_req(cfb_pkg::CMD_STATUS, 8'hA5);
        push_req(cfb_pkg::CMD_COLOUR, 8'h80);
        push_req(cfb_pkg::CMD_COLOUR, 8'h01);
        drain();

        cfg_write(cfb_pkg::REG_HEADER, 8'h00);
        cfg_write(cfb_pkg::REG_STATUS, 8'h00);
        cfg_write(cfb_pkg::REG_COLOUR, 8'h00);
        cfg_write(REG_SPARE, 8'hFF);
        push_req(cfb_pkg::CMD_STATUS, 8'h00);
        push_req(cfb_pkg::CMD_COLOUR, 8'h00);
        push_req(cfb_pkg::CMD_COLOUR, 8'hFF);
        push_req(cfb_pkg::CMD_STATUS, 8'hFF);
        drain();

        cfg_write(cfb_pkg::REG_HEADER, 8'hFF);
        cfg_write(cfb_pkg::REG_STATUS, 8'hFF);
        cfg_write(cfb_pkg::REG_COLOUR, 8'hFF);
        cfg_write(REG_SPARE, 8'h00);
        push_req(cfb_pkg::CMD_STATUS, 8'h00);
        push_req(cfb_pkg::CMD_COLOUR, 8'h00);
        push_req(cfb_pkg::CMD_COLOUR, 8'hFF);
        push_req(cfb_pkg::CMD_STATUS, 8'hFF);
        drain();

        cfg_write(cfb_pkg::REG_HEADER, 8'h00);
        cfg_write(cfb_pkg::REG_STATUS, 8'hFF);
        cfg_write(cfb_pkg::REG_COLOUR, 8'h00);
        push_req(cfb_pkg::CMD_STATUS, 8'h55);
        push_req(cfb_pkg::CMD_COLOUR, 8'hAA);
        push_req(cfb_pkg::CMD_COLOUR, 8'h7F);
        push_req(cfb_pkg::CMD_STATUS, 8'h00);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_idle(p / 3);
            cfg_write(cfb_pkg::REG_HEADER, edge_or_random_byte());
            cfg_write(cfb_pkg::REG_STATUS, edge_or_random_byte());
            cfg_write(cfb_pkg::REG_COLOUR, edge_or_random_byte());
            if ($urandom_range(1))
                cfg_write(REG_SPARE, 8'($urandom_range(255)));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_req(1'($urandom_range(1)), edge_or_random_byte());
            drain();
        end

        mismatches += frame_beats_due.size();
        $display("Checked %0d beats from %0d status and %0d colour frames",
                 beats_checked, status_frames, colour_frames);
        $display("Register sweeps covered all-zero, all-one and random codes plus spare-index writes");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/cfb_pkg.sv
sv/cfb_front.sv
sv/cfb_queue.sv
sv/cfb_back.sv
sv/command_frame_builder_crc8_core.sv
verif/tb_top.sv
